/* rtl/event_object_selection_trigger_top_macros.svh */
// assertion macros for the event object selection trigger
`ifndef EVENT_OBJECT_SELECTION_TRIGGER_TOP_MACROS_SVH
`define EVENT_OBJECT_SELECTION_TRIGGER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define EOST_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event selection trigger check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define EOST_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event selection trigger check failed");

`endif

/* rtl/eost_pkg.sv */
// shared types, constants and helpers of the event object selection trigger
`default_nettype none

package eost_pkg;

	// widths
	localparam int unsigned NUM_TYPES  = 4;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CTR_W      = 32;
	localparam int unsigned NUM_CTRS   = 6;

	// per-event object counts saturate here
	localparam logic [CNT_W-1:0] MAX_OBJECTS_PER_TYPE = 6'd32;

	// default depth of the queue between front and back end
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// item kinds
	localparam logic [2:0] KIND_JET      = 3'd0;
	localparam logic [2:0] KIND_ELECTRON = 3'd1;
	localparam logic [2:0] KIND_MUON     = 3'd2;
	localparam logic [2:0] KIND_PHOTON   = 3'd3;
	localparam logic [2:0] KIND_END      = 3'd4;

	// object type index (low bits of an object kind)
	localparam logic [1:0] TYPE_JET      = 2'd0;
	localparam logic [1:0] TYPE_ELECTRON = 2'd1;
	localparam logic [1:0] TYPE_MUON     = 2'd2;
	localparam logic [1:0] TYPE_PHOTON   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PT_MINS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ETA_LIMITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JET_CUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ELE_CUT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MUON_CUT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PHOTON_CUT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MET_MIN    = 3'd6;

	// failing stage codes
	localparam logic [2:0] STAGE_NONE     = 3'd0;
	localparam logic [2:0] STAGE_ELECTRON = 3'd1;
	localparam logic [2:0] STAGE_MUON     = 3'd2;
	localparam logic [2:0] STAGE_JET      = 3'd3;
	localparam logic [2:0] STAGE_PHOTON   = 3'd4;
	localparam logic [2:0] STAGE_MET      = 3'd5;

	// register reset values
	localparam logic [63:0] PT_MINS_RST    = 64'h0000_00C8_0000_0000;
	localparam logic [43:0] ETA_LIMITS_RST = {11'd640, 11'd640, 11'd640, 11'd640};

	// one multiplicity cut register
	typedef struct packed {
		logic             enable;
		logic             exact;
		logic [CNT_W-1:0] n;
		logic [15:0]      thr;
	} count_cut_t;

	// all configuration registers
	typedef struct packed {
		logic [63:0]                  pt_mins;
		logic [43:0]                  eta_limits;
		count_cut_t [NUM_TYPES-1:0]   cuts;
		logic [15:0]                  met_min;
	} cfg_t;

	// classified item passed from front to back end
	typedef struct packed {
		logic       is_end;
		logic [1:0] typ;
		logic       accepted;
		logic       above;
		logic       met_ok;
	} item_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// multiplicity cut check, exact jet cuts only fail on too few
	function automatic logic cut_pass(count_cut_t c, logic [CNT_W-1:0] cnt, logic is_jet);
		logic ok;
		ok = 1'b1;
		if (c.enable) begin
			if (c.exact && !is_jet) begin
				ok = (cnt == c.n);
			end else begin
				ok = (cnt >= c.n);
			end
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

/* rtl/eost_cfg.sv */
// configuration register file of the event object selection trigger
`default_nettype none

module eost_cfg
	import eost_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pt_mins    <= PT_MINS_RST;
			cfg_q.eta_limits <= ETA_LIMITS_RST;
			cfg_q.cuts       <= '0;
			cfg_q.met_min    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PT_MINS:    cfg_q.pt_mins <= cfg_data;
				REG_ETA_LIMITS: cfg_q.eta_limits <= cfg_data[43:0];
				REG_JET_CUT:    cfg_q.cuts[TYPE_JET] <= count_cut_t'(cfg_data[23:0]);
				REG_ELE_CUT:    cfg_q.cuts[TYPE_ELECTRON] <= count_cut_t'(cfg_data[23:0]);
				REG_MUON_CUT:   cfg_q.cuts[TYPE_MUON] <= count_cut_t'(cfg_data[23:0]);
				REG_PHOTON_CUT: cfg_q.cuts[TYPE_PHOTON] <= count_cut_t'(cfg_data[23:0]);
				REG_MET_MIN:    cfg_q.met_min <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/eost_front.sv */
// front end: accepts items, applies object acceptance and threshold tests
`default_nettype none

module eost_front
	import eost_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         kind,
	input  wire logic [15:0]        object_pt,
	input  wire logic signed [11:0] object_eta,
	input  wire logic [15:0]        met_value,
	input  wire q_stat_t            q_stat,
	output logic                    valid_s1,
	output item_t                   item_s1
);

	logic        is_obj;
	logic        is_end;
	logic [1:0]  typ;
	logic [11:0] eta_bits;
	logic [11:0] abs_eta;
	logic [10:0] eta_lim;
	logic [15:0] pt_min;
	logic [15:0] thr;
	logic        accepted;
	item_t       item_d;
	logic        valid_q;
	item_t       item_q;

	// classify the incoming transaction
	always_comb begin
		is_obj   = (kind[2] == 1'b0);
		is_end   = (kind == KIND_END);
		typ      = kind[1:0];
		eta_bits = object_eta;
		abs_eta  = eta_bits[11] ? (12'd0 - eta_bits) : eta_bits;
		eta_lim  = cfg.eta_limits[typ*11 +: 11];
		pt_min   = cfg.pt_mins[typ*16 +: 16];
		thr      = cfg.cuts[typ].thr;
		accepted = is_obj && (abs_eta <= {1'b0, eta_lim}) && (object_pt >= pt_min);
		item_d.is_end   = is_end;
		item_d.typ      = typ;
		item_d.accepted = accepted;
		item_d.above    = accepted && (object_pt > thr);
		item_d.met_ok   = (met_value >= cfg.met_min);
	end

	// hold only while a classified item waits on a full queue
	assign in_stall = valid_q && q_stat.full;

	// stage register, unused kinds are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid && (is_obj || is_end);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= item_d;
		end
	end

	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

endmodule

`default_nettype wire

/* rtl/eost_queue.sv */
// small first-in first-out queue between front and back end
`default_nettype none

module eost_queue
	import eost_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head,
	output q_stat_t    q_stat
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_Q_W = $clog2(DEPTH + 1);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_Q_W-1:0] count_q;
	logic               full;
	logic               empty;
	logic               push;

	assign full  = (count_q == CNT_Q_W'(DEPTH));
	assign empty = (count_q == '0);
	assign push  = push_valid && !full;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = full;
	assign q_stat.empty = empty;

endmodule

`default_nettype wire

/* rtl/eost_back.sv */
// back end: per-event counts, cut evaluation, pass counters and result register
`default_nettype none

module eost_back
	import eost_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire count_cut_t [NUM_TYPES-1:0] cuts,
	input  wire item_t                      head,
	input  wire q_stat_t                    q_stat,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            event_pass,
	output logic [2:0]                      fail_stage,
	output logic [CNT_W-1:0]                jets_kept,
	output logic [CTR_W-1:0]                events_seen,
	output logic [CTR_W-1:0]                electron_stage_passes,
	output logic [CTR_W-1:0]                muon_stage_passes,
	output logic [CTR_W-1:0]                jet_stage_passes,
	output logic [CTR_W-1:0]                photon_stage_passes,
	output logic [CTR_W-1:0]                met_stage_passes
);

	localparam int unsigned CTR_EVENTS = 0;
	localparam int unsigned CTR_ELE    = 1;
	localparam int unsigned CTR_MUON   = 2;
	localparam int unsigned CTR_JET    = 3;
	localparam int unsigned CTR_PHOTON = 4;
	localparam int unsigned CTR_MET    = 5;

	logic [CNT_W-1:0]                 jet_acc_q;
	logic [NUM_TYPES-1:0][CNT_W-1:0]  above_q;
	logic [CTR_W-1:0]                 ctr_q [NUM_CTRS];
	logic                             out_valid_q;
	logic                             pass_q;
	logic [2:0]                       stage_q;
	logic [CNT_W-1:0]                 kept_q;

	logic                             end_pop;
	logic                             e_ok;
	logic                             m_ok;
	logic                             j_ok;
	logic                             p_ok;
	logic [NUM_CTRS-1:0]              ctr_inc;
	logic [2:0]                       stage;
	logic                             trim;
	logic [CNT_W-1:0]                 kept;

	// an object always drains, an end transaction needs a free result slot
	assign pop     = !q_stat.empty && (!head.is_end || !out_valid_q || !out_stall);
	assign end_pop = pop && head.is_end;

	// cut chain in order electron, muon, jet, photon, met
	always_comb begin
		e_ok = cut_pass(cuts[TYPE_ELECTRON], above_q[TYPE_ELECTRON], 1'b0);
		m_ok = cut_pass(cuts[TYPE_MUON], above_q[TYPE_MUON], 1'b0);
		j_ok = cut_pass(cuts[TYPE_JET], above_q[TYPE_JET], 1'b1);
		p_ok = cut_pass(cuts[TYPE_PHOTON], above_q[TYPE_PHOTON], 1'b0);
		ctr_inc[CTR_EVENTS] = 1'b1;
		ctr_inc[CTR_ELE]    = e_ok;
		ctr_inc[CTR_MUON]   = ctr_inc[CTR_ELE] && m_ok;
		ctr_inc[CTR_JET]    = ctr_inc[CTR_MUON] && j_ok;
		ctr_inc[CTR_PHOTON] = ctr_inc[CTR_JET] && p_ok;
		ctr_inc[CTR_MET]    = ctr_inc[CTR_PHOTON] && head.met_ok;
		if (!ctr_inc[CTR_ELE]) begin
			stage = STAGE_ELECTRON;
		end else if (!ctr_inc[CTR_MUON]) begin
			stage = STAGE_MUON;
		end else if (!ctr_inc[CTR_JET]) begin
			stage = STAGE_JET;
		end else if (!ctr_inc[CTR_PHOTON]) begin
			stage = STAGE_PHOTON;
		end else if (!ctr_inc[CTR_MET]) begin
			stage = STAGE_MET;
		end else begin
			stage = STAGE_NONE;
		end
		// exact jet cut trims surplus jets once the jet stage is passed
		trim = ctr_inc[CTR_JET] && cuts[TYPE_JET].enable && cuts[TYPE_JET].exact &&
			(above_q[TYPE_JET] > cuts[TYPE_JET].n);
		kept = trim ? cuts[TYPE_JET].n : jet_acc_q;
	end

	// per-event object counts, cleared by the end transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jet_acc_q <= '0;
			above_q   <= '0;
		end else if (pop) begin
			if (head.is_end) begin
				jet_acc_q <= '0;
				above_q   <= '0;
			end else if (head.accepted) begin
				if (head.typ == TYPE_JET && jet_acc_q < MAX_OBJECTS_PER_TYPE) begin
					jet_acc_q <= jet_acc_q + 1'b1;
				end
				if (head.above && above_q[head.typ] < MAX_OBJECTS_PER_TYPE) begin
					above_q[head.typ] <= above_q[head.typ] + 1'b1;
				end
			end
		end
	end

	// saturating stage pass counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CTRS; i++) begin
				ctr_q[i] <= '0;
			end
		end else if (end_pop) begin
			for (int i = 0; i < NUM_CTRS; i++) begin
				if (ctr_inc[i] && ctr_q[i] != '1) begin
					ctr_q[i] <= ctr_q[i] + 1'b1;
				end
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (end_pop) begin
			pass_q  <= (stage == STAGE_NONE);
			stage_q <= stage;
			kept_q  <= kept;
		end
	end

	assign out_valid             = out_valid_q;
	assign event_pass            = pass_q;
	assign fail_stage            = stage_q;
	assign jets_kept             = kept_q;
	assign events_seen           = ctr_q[CTR_EVENTS];
	assign electron_stage_passes = ctr_q[CTR_ELE];
	assign muon_stage_passes     = ctr_q[CTR_MUON];
	assign jet_stage_passes      = ctr_q[CTR_JET];
	assign photon_stage_passes   = ctr_q[CTR_PHOTON];
	assign met_stage_passes      = ctr_q[CTR_MET];

endmodule

`default_nettype wire

/* rtl/event_object_selection_trigger_top.sv */
// Event object selection trigger. Takes one transaction per clock unless
// in_stall is high: object transactions (jet, electron, muon, photon) are
// tested against per-type pT minimum and |eta| limit in the front end and
// counted per event in the back end; an end-of-event transaction applies the
// electron, muon, jet, photon and MET cuts in that order and returns one
// result with the saturating stage pass counters. Kinds 5 to 7 are dropped.
// A classified transaction goes through the front register and a
// QUEUE_DEPTH-entry queue before the back end registers its result.
// Sustained rate is one transaction per cycle while the queue is not full;
// an end-of-event transaction holds the back end only while the previous
// result is still stalled in the output register, and the queue absorbs that
// wait. Configuration writes take effect on the next clock.
`default_nettype none
`include "event_object_selection_trigger_top_macros.svh"

module event_object_selection_trigger_top
	import eost_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [2:0]             kind,
	input  wire logic [15:0]            object_pt,
	input  wire logic signed [11:0]     object_eta,
	input  wire logic [15:0]            met_value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        event_pass,
	output logic [2:0]                  fail_stage,
	output logic [CNT_W-1:0]            jets_kept,
	output logic [CTR_W-1:0]            events_seen,
	output logic [CTR_W-1:0]            electron_stage_passes,
	output logic [CTR_W-1:0]            muon_stage_passes,
	output logic [CTR_W-1:0]            jet_stage_passes,
	output logic [CTR_W-1:0]            photon_stage_passes,
	output logic [CTR_W-1:0]            met_stage_passes
);

	cfg_t    cfg;
	logic    valid_s1;
	item_t   item_s1;
	item_t   q_head;
	q_stat_t q_stat;
	logic    q_pop;

	// configuration registers
	eost_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// front end classification
	eost_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.object_pt  (object_pt),
		.object_eta (object_eta),
		.met_value  (met_value),
		.q_stat     (q_stat),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// decoupling queue
	eost_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (valid_s1),
		.push_item  (item_s1),
		.pop        (q_pop),
		.head       (q_head),
		.q_stat     (q_stat)
	);

	// back end counting and cut evaluation
	eost_back u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cuts                  (cfg.cuts),
		.head                  (q_head),
		.q_stat                (q_stat),
		.pop                   (q_pop),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.event_pass            (event_pass),
		.fail_stage            (fail_stage),
		.jets_kept             (jets_kept),
		.events_seen           (events_seen),
		.electron_stage_passes (electron_stage_passes),
		.muon_stage_passes     (muon_stage_passes),
		.jet_stage_passes      (jet_stage_passes),
		.photon_stage_passes   (photon_stage_passes),
		.met_stage_passes      (met_stage_passes)
	);

	// checks
	`EOST_ASSERT_IMP(a_queue_full_empty, 1'b1, !(q_stat.full && q_stat.empty))
	`EOST_ASSERT_NXT(a_end_gives_result, q_pop && q_head.is_end, out_valid)
	`EOST_ASSERT_IMP(a_counters_move_with_result, !$stable(events_seen), out_valid)
	`EOST_ASSERT_IMP(a_met_below_photon, 1'b1, met_stage_passes <= photon_stage_passes)
	`EOST_ASSERT_IMP(a_pass_has_no_stage, out_valid && event_pass, fail_stage == STAGE_NONE)

endmodule

`default_nettype wire
